[rtl/core/brake_chopper_pulse_test_assert.svh]
// Assertion macros used by the brake chopper pulse test checker.
`ifndef BRAKE_CHOPPER_PULSE_TEST_ASSERT_SVH
`define BRAKE_CHOPPER_PULSE_TEST_ASSERT_SVH

// Consequent must hold at the same edge as the antecedent.
`define BCPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold at the edge after the antecedent.
`define BCPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/bcpt_pkg.sv]
// Types and constants of the brake chopper pulse test sequencer.
`default_nettype none
package bcpt_pkg;

    localparam int CNT_W_DEF   = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int SEL_W       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_SELECT = 1'b0,
        REG_PULSE_COUNT  = 1'b1
    } t_cfg_reg;

    typedef enum logic [SEL_W-1:0] {
        SEL_GATE_ONE = 2'd0,
        SEL_GATE_TWO = 2'd1,
        SEL_BOTH     = 2'd2,
        SEL_HOLD     = 2'd3
    } t_pulse_sel;

    typedef enum logic [1:0] {
        PP_NORMAL = 2'd0,
        PP_INIT   = 2'd1,
        PP_PULSE  = 2'd2,
        PP_STOP   = 2'd3
    } t_pulse_phase;

    typedef enum logic [2:0] {
        SP_IDLE      = 3'd0,
        SP_WAIT_REQ  = 3'd1,
        SP_PREPARE   = 3'd2,
        SP_START     = 3'd3,
        SP_WAIT_DONE = 3'd4,
        SP_FINISHED  = 3'd5,
        SP_SHUT_A    = 3'd6,
        SP_SHUT_B    = 3'd7
    } t_sup_phase;

    typedef struct packed {
        logic command;
        logic test_request;
        logic trip_fault;
    } t_item;

    typedef struct packed {
        logic gate_one;
        logic gate_two;
        logic pulsing;
        logic test_active;
        logic test_done;
    } t_result;

endpackage
`default_nettype wire

[rtl/core/bcpt_item_if.sv]
// Valid/ready channel that carries one input item.
`default_nettype none
interface bcpt_item_if import bcpt_pkg::*; ();
    logic  valid;
    logic  ready;
    t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/bcpt_result_if.sv]
// Valid/ready channel that carries one result item.
`default_nettype none
interface bcpt_result_if import bcpt_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/brake_chopper_pulse_test.sv]
// Dynamic-brake pulse test sequencer. Every accepted beat is one tick: command 1 is a slow
// supervisory tick (request decode, trip abort, count load, ready/done handshake, two-step
// shutdown), command 0 a fast pulse tick (copy count, drive gate one, two or both for that
// many ticks, flag done). Each beat yields exactly one result beat with the flags after the
// update. One beat is accepted per cycle while the skid register is empty. The state
// update is a single step of short logic; its result is held in the result register, or
// in the skid register while the output stalls. The two-entry output stage keeps the
// input open while one result waits. The loaded count is masked to COUNT_WIDTH bits.
`default_nettype none
module brake_chopper_pulse_test import bcpt_pkg::*; #(
    parameter int COUNT_WIDTH = CNT_W_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    bcpt_item_if.sink                  i_item,
    bcpt_result_if.source              o_result
);

    // configuration
    logic [SEL_W-1:0]      r_pulse_select;
    logic [CFG_DATA_W-1:0] r_pulse_count;

    // sequencer state
    t_pulse_phase           r_pp, n_pp;
    t_sup_phase             r_sp, n_sp;
    logic [COUNT_WIDTH-1:0] r_left, n_left;
    logic [COUNT_WIDTH-1:0] r_loaded, n_loaded;
    logic                   r_ready_f, n_ready_f;
    logic                   r_done_f, n_done_f;
    logic                   r_gate1, n_gate1;
    logic                   r_gate2, n_gate2;
    logic                   r_pulsing, n_pulsing;
    logic                   r_active, n_active;
    logic                   r_finished, n_finished;

    // output stage
    logic    r_out_valid, r_skid_valid;
    t_result r_out_data, r_skid_data;
    t_result w_res;

    logic                              w_in_fire, w_out_fire;
    logic [2:0]                        w_kind;
    t_sup_phase                        w_sp_dec;
    logic [COUNT_WIDTH+CFG_DATA_W-1:0] w_cnt_ext;

    assign w_cnt_ext  = {{COUNT_WIDTH{1'b0}}, r_pulse_count};
    assign i_item.ready = !r_skid_valid;
    assign w_in_fire  = i_item.valid && !r_skid_valid;
    assign w_out_fire = r_out_valid && o_result.ready;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

    assign w_kind = {r_active, r_finished, i_item.data.test_request};

    // next state of both machines
    always_comb begin
        n_pp       = r_pp;
        n_sp       = r_sp;
        n_left     = r_left;
        n_loaded   = r_loaded;
        n_ready_f  = r_ready_f;
        n_done_f   = r_done_f;
        n_gate1    = r_gate1;
        n_gate2    = r_gate2;
        n_pulsing  = r_pulsing;
        n_active   = r_active;
        n_finished = r_finished;
        w_sp_dec   = r_sp;

        if (i_item.data.command) begin
            // decode request, finished and active into an entry phase
            case (w_kind)
                3'd0, 3'd3: w_sp_dec = SP_IDLE;
                3'd1, 3'd7: w_sp_dec = i_item.data.trip_fault ? SP_IDLE : SP_WAIT_REQ;
                3'd2, 3'd4: w_sp_dec = (r_sp == SP_SHUT_B) ? SP_SHUT_B : SP_SHUT_A;
                default:    w_sp_dec = r_sp;
            endcase
            n_sp = w_sp_dec;
            case (w_sp_dec)
                SP_IDLE: n_sp = SP_IDLE;
                SP_WAIT_REQ: begin
                    n_active = 1'b1;
                    n_sp     = SP_PREPARE;
                end
                SP_PREPARE: begin
                    n_loaded = w_cnt_ext[COUNT_WIDTH-1:0];
                    n_sp     = SP_START;
                end
                SP_START: begin
                    n_ready_f = 1'b1;
                    n_sp      = SP_WAIT_DONE;
                end
                SP_WAIT_DONE: begin
                    if (i_item.data.trip_fault || !i_item.data.test_request) begin
                        n_sp = SP_SHUT_A;
                    end else if (r_done_f) begin
                        n_sp = SP_FINISHED;
                    end
                end
                SP_FINISHED: begin
                    n_finished = 1'b1;
                    n_active   = 1'b0;
                    n_sp       = SP_SHUT_A;
                end
                SP_SHUT_A: begin
                    n_loaded  = '0;
                    n_ready_f = 1'b0;
                    n_sp      = SP_SHUT_B;
                end
                default: begin
                    n_active   = 1'b0;
                    n_finished = 1'b0;
                    n_sp       = SP_WAIT_REQ;
                end
            endcase
        end else if (!r_active) begin
            // pulse machine off: clear count, phase, pulsing flag and gates
            n_left    = '0;
            n_pp      = PP_NORMAL;
            n_pulsing = 1'b0;
            n_gate1   = 1'b0;
            n_gate2   = 1'b0;
        end else begin
            case (r_pp)
                PP_NORMAL: begin
                    n_done_f  = 1'b0;
                    n_pulsing = r_ready_f;
                    if (r_ready_f) begin
                        n_pp   = PP_INIT;
                        n_left = '0;
                    end
                    n_gate1 = 1'b0;
                    n_gate2 = 1'b0;
                end
                PP_INIT: begin
                    n_left = r_loaded;
                    n_pp   = PP_PULSE;
                end
                PP_PULSE: begin
                    if (r_left != '0) begin
                        case (r_pulse_select)
                            SEL_GATE_ONE: begin n_gate1 = 1'b1; n_gate2 = 1'b0; end
                            SEL_GATE_TWO: begin n_gate1 = 1'b0; n_gate2 = 1'b1; end
                            SEL_BOTH:     begin n_gate1 = 1'b1; n_gate2 = 1'b1; end
                            default:      begin n_gate1 = r_gate1; n_gate2 = r_gate2; end
                        endcase
                        n_left = r_left - COUNT_WIDTH'(1);
                    end else begin
                        n_gate1  = 1'b0;
                        n_gate2  = 1'b0;
                        n_done_f = 1'b1;
                        n_pp     = PP_STOP;
                    end
                end
                default: begin
                    if (!r_ready_f) begin
                        n_pp = PP_NORMAL;
                    end
                    n_gate1 = 1'b0;
                    n_gate2 = 1'b0;
                end
            endcase
        end
    end

    // result beat: flags after the update
    always_comb begin
        w_res.gate_one    = n_gate1;
        w_res.gate_two    = n_gate2;
        w_res.pulsing     = n_pulsing;
        w_res.test_active = n_active;
        w_res.test_done   = n_finished;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_select <= SEL_GATE_ONE;
            r_pulse_count  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_PULSE_SELECT: r_pulse_select <= i_cfg_data[SEL_W-1:0];
                REG_PULSE_COUNT:  r_pulse_count  <= i_cfg_data;
                default:          r_pulse_count  <= r_pulse_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp       <= PP_NORMAL;
            r_sp       <= SP_WAIT_REQ;
            r_left     <= '0;
            r_loaded   <= '0;
            r_ready_f  <= 1'b0;
            r_done_f   <= 1'b0;
            r_gate1    <= 1'b0;
            r_gate2    <= 1'b0;
            r_pulsing  <= 1'b0;
            r_active   <= 1'b0;
            r_finished <= 1'b0;
        end else if (w_in_fire) begin
            r_pp       <= n_pp;
            r_sp       <= n_sp;
            r_left     <= n_left;
            r_loaded   <= n_loaded;
            r_ready_f  <= n_ready_f;
            r_done_f   <= n_done_f;
            r_gate1    <= n_gate1;
            r_gate2    <= n_gate2;
            r_pulsing  <= n_pulsing;
            r_active   <= n_active;
            r_finished <= n_finished;
        end
    end

    // result register plus skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_fire) begin
            if (!r_out_valid || w_out_fire) begin
                r_out_data  <= w_res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_data  <= w_res;
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

[rtl/core/bcpt_checker.sv]
// Port-level checks on the result channel of the pulse test sequencer.
`include "brake_chopper_pulse_test_assert.svh"
`default_nettype none
module bcpt_checker import bcpt_pkg::*; (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    i_valid,
    input wire logic    i_ready,
    input wire t_result i_data
);

    logic w_gate_on;

    assign w_gate_on = i_data.gate_one || i_data.gate_two;

    // a stalled result beat stays and holds its payload
    `BCPT_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_data))

    // the test is never active and finished at once
    `BCPT_ASSERT_NOW(a_act_fin, i_clk, i_rst_n, i_valid, !(i_data.test_active && i_data.test_done))

    // a gate is on only inside a pulse train
    `BCPT_ASSERT_NOW(a_gate_pulse, i_clk, i_rst_n, i_valid && w_gate_on, i_data.pulsing)

endmodule

bind brake_chopper_pulse_test bcpt_checker u_bcpt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_result.valid),
    .i_ready (o_result.ready),
    .i_data  (o_result.data)
);
`default_nettype wire
